// ----- rtl/tbpa_pkg.sv -----
// shared types and constants of the block table pool allocator
package tbpa_pkg;

   localparam int BLOCK_BYTES   = 32;
   localparam int TABLE_ENTRIES = 1024;
   localparam int POOL_BYTES    = 32768;

   localparam int BLK_SH  = $clog2(BLOCK_BYTES);
   localparam int TBL_AW  = $clog2(TABLE_ENTRIES);
   localparam int CNT_W   = TBL_AW + 1;
   localparam int MAP_W   = 16;
   localparam int LEN_W   = 15;
   localparam int PCT_W   = 7;
   localparam int PROD_W  = CNT_W + 7;
   localparam int PCT_MUL = 100;

   localparam logic [1:0] OP_ALLOC = 2'd0;
   localparam logic [1:0] OP_FREE  = 2'd1;
   localparam logic [1:0] OP_SWEEP = 2'd2;

   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_NOT_READY  = 2'd1;
   localparam logic [1:0] ST_BAD_OFFSET = 2'd2;
   localparam logic [1:0] ST_NO_FIT     = 2'd3;

   typedef struct packed {
      logic [1:0]  operation;
      logic [19:0] size_bytes;
      logic        protect;
      logic [19:0] free_offset;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [14:0] alloc_offset;
      logic [6:0]  usage_percent;
   } rsp_type;

   typedef struct packed {
      logic             done;
      logic [1:0]       status;
      logic [14:0]      alloc_offset;
      logic [CNT_W-1:0] used;
   } done_type;

endpackage

// ----- rtl/tbpa_ram.sv -----
// generic simple dual port ram with registered read
module tbpa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- rtl/tbpa_ctrl.sv -----
// map sequencer: search, run write, free, sweep and clearing pass
module tbpa_ctrl import tbpa_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  req_type           item,
   input  logic              slot_free,
   input  logic [MAP_W-1:0]  rd_data,
   output logic [TBL_AW-1:0] rd_addr,
   output logic              wr_en,
   output logic [TBL_AW-1:0] wr_addr,
   output logic [MAP_W-1:0]  wr_data,
   output logic              idle,
   output done_type          result
);
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_CLEAR = 4'd1;
   localparam logic [3:0] S_ACHK  = 4'd2;
   localparam logic [3:0] S_LOOP  = 4'd3;
   localparam logic [3:0] S_E     = 4'd4;
   localparam logic [3:0] S_E2    = 4'd5;
   localparam logic [3:0] S_FLEN  = 4'd6;
   localparam logic [3:0] S_WRD   = 4'd7;
   localparam logic [3:0] S_WWR   = 4'd8;
   localparam logic [3:0] S_DONE  = 4'd9;

   localparam logic [1:0] M_ALLOC = 2'd0;
   localparam logic [1:0] M_FREE  = 2'd1;
   localparam logic [1:0] M_SWEEP = 2'd2;

   localparam logic [CNT_W-1:0] TBL = CNT_W'(TABLE_ENTRIES);

   logic [3:0]        state_ff, state_in;
   logic [1:0]        op_ff, op_in;
   logic [19:0]       size_ff, size_in;
   logic              prot_ff, prot_in;
   logic              ready_ff, ready_in;
   logic [CNT_W-1:0]  used_ff, used_in;
   logic [TBL_AW-1:0] n_ff, n_in;
   logic [TBL_AW-1:0] cand_ff, cand_in;
   logic [TBL_AW-1:0] i_ff, i_in;
   logic [TBL_AW-1:0] c_ff, c_in;
   logic [MAP_W-1:0]  e_ff, e_in;
   logic [CNT_W-1:0]  addr_ff, addr_in;
   logic [CNT_W-1:0]  end_ff, end_in;
   logic [1:0]        mode_ff, mode_in;
   logic [1:0]        status_ff, status_in;
   logic [14:0]       aoff_ff, aoff_in;

   logic [CNT_W-1:0]  p;
   logic [CNT_W-1:0]  ic;
   logic [20:0]       nsum;
   logic [15:0]       n_full;
   logic [14:0]       fidx;
   logic [15:0]       fend;
   logic [CNT_W-1:0]  aend;
   logic [LEN_W-1:0]  elen;

   assign p      = CNT_W'(cand_ff) + CNT_W'(i_ff);
   assign ic     = CNT_W'(c_ff) + CNT_W'(i_ff);
   assign nsum   = 21'(size_ff) + 21'(BLOCK_BYTES - 1);
   assign n_full = 16'(nsum >> BLK_SH);
   assign fidx   = item.free_offset[19:BLK_SH];
   assign fend   = 16'(addr_ff) + 16'(rd_data[LEN_W-1:0]);
   assign aend   = CNT_W'(cand_ff) + CNT_W'(n_ff);
   assign elen   = e_ff[LEN_W-1:0];

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      size_in   = size_ff;
      prot_in   = prot_ff;
      ready_in  = ready_ff;
      used_in   = used_ff;
      n_in      = n_ff;
      cand_in   = cand_ff;
      i_in      = i_ff;
      c_in      = c_ff;
      e_in      = e_ff;
      addr_in   = addr_ff;
      end_in    = end_ff;
      mode_in   = mode_ff;
      status_in = status_ff;
      aoff_in   = aoff_ff;
      rd_addr   = p[TBL_AW-1:0];
      wr_en     = 1'b0;
      wr_addr   = addr_ff[TBL_AW-1:0];
      wr_data   = '0;

      case (state_ff)
         S_IDLE: begin
            rd_addr = fidx[TBL_AW-1:0];
            if (start) begin
               op_in     = item.operation;
               size_in   = item.size_bytes;
               prot_in   = item.protect;
               status_in = ST_OK;
               aoff_in   = '0;
               addr_in   = '0;
               case (item.operation)
                  OP_ALLOC: begin
                     state_in = ready_ff ? S_ACHK : S_CLEAR;
                  end
                  OP_FREE: begin
                     if (!ready_ff) begin
                        state_in = S_CLEAR;
                     end else if (32'(item.free_offset) >= 32'(POOL_BYTES)) begin
                        status_in = ST_BAD_OFFSET;
                        state_in  = S_DONE;
                     end else if (32'(fidx) >= 32'(TABLE_ENTRIES)) begin
                        state_in = S_DONE;
                     end else begin
                        addr_in  = CNT_W'(fidx);
                        state_in = S_FLEN;
                     end
                  end
                  OP_SWEEP: begin
                     // sweep does nothing before the first clear of the map
                     if (ready_ff) begin
                        mode_in  = M_SWEEP;
                        end_in   = TBL;
                        state_in = S_WRD;
                     end else begin
                        state_in = S_DONE;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_CLEAR: begin
            wr_en   = 1'b1;
            addr_in = addr_ff + 1'b1;
            if (addr_ff == TBL - 1'b1) begin
               ready_in = 1'b1;
               used_in  = '0;
               if (op_ff == OP_ALLOC) begin
                  state_in = S_ACHK;
               end else begin
                  status_in = ST_NOT_READY;
                  state_in  = S_DONE;
               end
            end
         end
         S_ACHK: begin
            if (size_ff == '0 || n_full >= 16'(TABLE_ENTRIES)) begin
               status_in = ST_NO_FIT;
               state_in  = S_DONE;
            end else begin
               n_in     = n_full[TBL_AW-1:0];
               cand_in  = TBL_AW'(TBL - CNT_W'(n_full));
               i_in     = '0;
               c_in     = '0;
               state_in = S_LOOP;
            end
         end
         S_LOOP: begin
            if (ic == CNT_W'(n_ff)) begin
               aoff_in  = 15'(cand_ff) << BLK_SH;
               addr_in  = CNT_W'(cand_ff);
               end_in   = (aend > TBL) ? TBL : aend;
               mode_in  = M_ALLOC;
               state_in = S_WRD;
            end else if (p >= TBL) begin
               i_in = i_ff + 1'b1;
            end else begin
               state_in = S_E;
            end
         end
         S_E: begin
            rd_addr = TBL_AW'(p - 1'b1);
            if (rd_data == '0) begin
               i_in     = i_ff + 1'b1;
               state_in = S_LOOP;
            end else if (p < CNT_W'(n_ff)) begin
               status_in = ST_NO_FIT;
               state_in  = S_DONE;
            end else begin
               e_in     = rd_data;
               state_in = S_E2;
            end
         end
         S_E2: begin
            state_in = S_LOOP;
            c_in     = i_ff;
            i_in     = '0;
            if (rd_data == e_ff) begin
               if (16'(p) > 16'(elen)) begin
                  cand_in = TBL_AW'(p - CNT_W'(elen));
               end else begin
                  status_in = ST_NO_FIT;
                  state_in  = S_DONE;
               end
            end else begin
               cand_in = TBL_AW'(p - CNT_W'(n_ff));
            end
         end
         S_FLEN: begin
            end_in   = (fend > 16'(TABLE_ENTRIES)) ? TBL : CNT_W'(fend);
            mode_in  = M_FREE;
            state_in = S_WRD;
         end
         S_WRD: begin
            rd_addr = addr_ff[TBL_AW-1:0];
            if (addr_ff >= end_ff) begin
               state_in = S_DONE;
            end else begin
               state_in = S_WWR;
            end
         end
         S_WWR: begin
            addr_in  = addr_ff + 1'b1;
            state_in = S_WRD;
            case (mode_ff)
               M_ALLOC: begin
                  wr_en   = 1'b1;
                  wr_data = {prot_ff, LEN_W'(n_ff)};
                  if (rd_data == '0) begin
                     used_in = used_ff + 1'b1;
                  end
               end
               M_FREE: begin
                  wr_en = 1'b1;
                  if (rd_data != '0) begin
                     used_in = used_ff - 1'b1;
                  end
               end
               default: begin
                  if (!rd_data[MAP_W-1]) begin
                     wr_en = 1'b1;
                     if (rd_data != '0) begin
                        used_in = used_ff - 1'b1;
                     end
                  end
               end
            endcase
         end
         S_DONE: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b0;
         used_ff  <= '0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
         used_ff  <= used_in;
      end
      op_ff     <= op_in;
      size_ff   <= size_in;
      prot_ff   <= prot_in;
      n_ff      <= n_in;
      cand_ff   <= cand_in;
      i_ff      <= i_in;
      c_ff      <= c_in;
      e_ff      <= e_in;
      addr_ff   <= addr_in;
      end_ff    <= end_in;
      mode_ff   <= mode_in;
      status_ff <= status_in;
      aoff_ff   <= aoff_in;
   end

   assign idle                = (state_ff == S_IDLE);
   assign result.done         = (state_ff == S_DONE);
   assign result.status       = status_ff;
   assign result.alloc_offset = aoff_ff;
   assign result.used         = used_ff;

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= TBL)
      else $error("used count above table size");

   a_write_state: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == S_WWR || state_ff == S_CLEAR))
      else $error("map write outside a write state");

   a_ready_sticky: assert property (@(posedge clock) disable iff (reset)
      ready_ff |=> ready_ff)
      else $error("ready flag dropped");

   a_done_fit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && status_ff != ST_OK) |-> aoff_ff == '0)
      else $error("offset reported on a failed item");
endmodule

// ----- rtl/block_table_pool_allocator_top.sv -----
// top level of the block table pool allocator
// One item at a time: allocate, free or sweep over a 1024 x 16 block map held
// in a single synchronous ram (one read and one write port, registered read).
// Free and sweep read and then write each map entry touched; an allocate
// reads one entry per probe of the downward search (and compares an entry with
// its neighbor below when needed, with no read for a probe past the table end),
// then reads and writes each block of the run. The first allocate or free
// after reset adds a clearing pass over the map. A finished result sits in the
// output register, and the next item may be taken while it waits there.
module block_table_pool_allocator_top import tbpa_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_item,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_item
);
   // map ram ports
   logic              wr_en;
   logic [TBL_AW-1:0] wr_addr;
   logic [MAP_W-1:0]  wr_data;
   logic [TBL_AW-1:0] rd_addr;
   logic [MAP_W-1:0]  rd_data;

   logic              idle;
   logic              slot_free;
   done_type          result;

   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_item_ff, rsp_item_in;
   logic [PROD_W-1:0] prod;

   // output slot opens when empty or being drained this cycle
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   // sequencer takes a new item only from idle
   assign req_stall = !idle;

   tbpa_ram #(
      .WIDTH (MAP_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   tbpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (req_valid && !req_stall),
      .item      (req_item),
      .slot_free (slot_free),
      .rd_data   (rd_data),
      .rd_addr   (rd_addr),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .idle      (idle),
      .result    (result)
   );

   // usage percent: used * 100 / entries, entries is a power of two
   assign prod = PROD_W'(result.used) * PROD_W'(PCT_MUL);

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_item_in  = rsp_item_ff;
      if (result.done && slot_free) begin
         rsp_valid_in               = 1'b1;
         rsp_item_in.status         = result.status;
         rsp_item_in.alloc_offset   = result.alloc_offset;
         rsp_item_in.usage_percent  = PCT_W'(prod >> TBL_AW);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;
endmodule

// ----- tb/block_table_pool_allocator_top_tb.sv -----
// testbench of the block table pool allocator: directed and random items checked against a predictor
module block_table_pool_allocator_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tbpa_pkg::*;

   // operation code with no effect
   localparam logic [1:0] OP_NOP = 2'd3;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_item = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_item;

   block_table_pool_allocator_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predicted state of the allocator
   logic [MAP_W-1:0] shadow_map [TABLE_ENTRIES];
   logic             shadow_ready = 1'b0;
   int               shadow_used = 0;

   rsp_type pending_rsp [$];     // results still owed by the block
   int      live_offsets [$];    // offsets handed out by successful allocates
   int      error_count = 0;
   bit      quiet = 1'b0;        // no random idling while set
   int      hold_ticket = 0;     // bumped to ask the receiver for a long hold

   initial begin
      foreach (shadow_map[k]) shadow_map[k] = '0;
   end

   function automatic bit roll_idle();
      return !quiet && ($urandom_range(0, 99) < 8);
   endfunction

   function automatic logic [MAP_W-1:0] shadow_at(int idx);
      return (idx >= 0 && idx < TABLE_ENTRIES) ? shadow_map[idx] : '0;
   endfunction

   function automatic void shadow_clear();
      foreach (shadow_map[k]) shadow_map[k] = '0;
      shadow_used = 0;
   endfunction

   // downward search with the skip rule; returns the start block or -1
   function automatic int find_run(int n);
      int cand, i, c, p, ln;
      logic [MAP_W-1:0] e;
      cand = TABLE_ENTRIES - n;
      i = 0;
      c = 0;
      while (i + c < n) begin
         p = cand + i;
         e = shadow_at(p);
         if (e != '0) begin
            if (p < n) return -1;
            ln = e[LEN_W-1:0];
            if (shadow_at(p - 1) == e) begin
               if (p > ln) cand = p - ln;
               else return -1;
            end else begin
               cand = p - n;
            end
            c = i;
            i = 0;
         end else begin
            i++;
         end
      end
      return cand;
   endfunction

   // applies one item to the shadow state and returns the expected result
   function automatic rsp_type apply_item(req_type it);
      rsp_type r;
      int n, cand, idx, ln;
      r = '0;
      case (it.operation)
         OP_ALLOC: begin
            if (!shadow_ready) begin
               shadow_clear();
               shadow_ready = 1'b1;
            end
            n = (int'(it.size_bytes) + BLOCK_BYTES - 1) / BLOCK_BYTES;
            cand = -1;
            if (it.size_bytes != 0 && n < TABLE_ENTRIES) cand = find_run(n);
            if (cand < 0) begin
               r.status = ST_NO_FIT;
            end else begin
               // a run may hang past the table end; only entries inside count
               for (int k = 0; k < n && cand + k < TABLE_ENTRIES; k++) begin
                  if (shadow_map[cand + k] == '0) shadow_used++;
                  shadow_map[cand + k] = {it.protect, LEN_W'(n)};
               end
               r.alloc_offset = LEN_W'(cand * BLOCK_BYTES);
               live_offsets.push_back(cand * BLOCK_BYTES);
            end
         end
         OP_FREE: begin
            if (!shadow_ready) begin
               shadow_clear();
               shadow_ready = 1'b1;
               r.status = ST_NOT_READY;
            end else if (it.free_offset >= POOL_BYTES) begin
               r.status = ST_BAD_OFFSET;
            end else begin
               idx = it.free_offset / BLOCK_BYTES;
               if (idx < TABLE_ENTRIES) begin
                  ln = shadow_map[idx][LEN_W-1:0];
                  for (int k = 0; k < ln && idx + k < TABLE_ENTRIES; k++) begin
                     if (shadow_map[idx + k] != '0) shadow_used--;
                     shadow_map[idx + k] = '0;
                  end
               end
            end
         end
         OP_SWEEP: begin
            foreach (shadow_map[k]) begin
               if (!shadow_map[k][MAP_W-1]) begin
                  if (shadow_map[k] != '0) shadow_used--;
                  shadow_map[k] = '0;
               end
            end
         end
         default: ;
      endcase
      r.usage_percent = PCT_W'(shadow_used * PCT_MUL / TABLE_ENTRIES);
      return r;
   endfunction

   // offers one item and waits until the block takes it; valid stays high
   task automatic send_item(req_type it);
      @(negedge clock);
      while (roll_idle()) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= it;
      do @(posedge clock); while (req_stall);
      pending_rsp.push_back(apply_item(it));
   endtask

   task automatic end_burst();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic send_op(logic [1:0] op, int size, bit prot, int off);
      req_type it;
      it.operation   = op;
      it.size_bytes  = 20'(size);
      it.protect     = prot;
      it.free_offset = 20'(off);
      send_item(it);
   endtask

   task automatic wait_drained();
      end_burst();
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   // receiver side: random stall, plus a long counted hold on request
   int hold_seen = 0;
   int hold_left = 0;
   always @(negedge clock) begin
      if (hold_ticket != hold_seen) begin
         hold_seen <= hold_ticket;
         hold_left <= 12000;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= roll_idle();
      end
   end

   // result checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %p", $time, rsp_item);
            error_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_item.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d",
                        $time, want.status, rsp_item.status);
               error_count++;
            end
            if (rsp_item.alloc_offset !== want.alloc_offset) begin
               $display("%0t: alloc_offset expected %0d actual %0d",
                        $time, want.alloc_offset, rsp_item.alloc_offset);
               error_count++;
            end
            if (rsp_item.usage_percent !== want.usage_percent) begin
               $display("%0t: usage_percent expected %0d actual %0d",
                        $time, want.usage_percent, rsp_item.usage_percent);
               error_count++;
            end
         end
      end
   end

   // sweep and free before the map was ever cleared, then first allocate
   task automatic test_before_ready();
      send_op(OP_SWEEP, 0, 1'b0, 0);
      send_op(OP_FREE, 0, 1'b0, 64);
      send_op(OP_ALLOC, 100, 1'b1, 0);
      end_burst();
   endtask

   // size extremes and rounding to whole blocks
   task automatic test_alloc_edges();
      send_op(OP_ALLOC, 0, 1'b0, 0);
      send_op(OP_ALLOC, 1, 1'b0, 0);
      send_op(OP_ALLOC, BLOCK_BYTES, 1'b1, 0);
      send_op(OP_ALLOC, BLOCK_BYTES + 1, 1'b0, 0);
      send_op(OP_ALLOC, TABLE_ENTRIES * BLOCK_BYTES, 1'b0, 0);
      send_op(OP_ALLOC, 20'hFFFFF, 1'b1, 0);
      send_op(OP_ALLOC, (TABLE_ENTRIES - 1) * BLOCK_BYTES, 1'b0, 0);
      send_op(OP_ALLOC, 4000, 1'b0, 0);
      end_burst();
   endtask

   // offsets past the pool, unused blocks, and real runs
   task automatic test_free_edges();
      send_op(OP_FREE, 0, 1'b0, POOL_BYTES);
      send_op(OP_FREE, 20'hFFFFF, 1'b0, 20'hFFFFF);
      send_op(OP_FREE, 0, 1'b0, 0);
      send_op(OP_FREE, 0, 1'b0, POOL_BYTES - 1);
      if (live_offsets.size() > 0) send_op(OP_FREE, 0, 1'b0, live_offsets[0]);
      if (live_offsets.size() > 1) send_op(OP_FREE, 0, 1'b0, live_offsets[1] + 5);
      end_burst();
   endtask

   // sweep keeps protected runs; operation three is a no-op
   task automatic test_sweep_and_misc();
      send_op(OP_ALLOC, 300, 1'b1, 0);
      send_op(OP_ALLOC, 700, 1'b0, 0);
      send_op(OP_NOP, 20'hFFFFF, 1'b1, 20'hFFFFF);
      send_op(OP_SWEEP, 0, 1'b0, 0);
      send_op(OP_SWEEP, 0, 1'b1, 0);
      end_burst();
   endtask

   function automatic req_type random_item();
      req_type it;
      int sel;
      it = '0;
      it.protect = $urandom_range(0, 3) == 0;
      sel = $urandom_range(0, 99);
      if (sel < 50) begin
         it.operation = OP_ALLOC;
         case ($urandom_range(0, 9))
            0:       it.size_bytes = 20'($urandom());
            1, 2:    it.size_bytes = 20'($urandom_range(1, 12000));
            default: it.size_bytes = 20'($urandom_range(1, 600));
         endcase
         if ($urandom_range(0, 3) == 0) it.free_offset = 20'($urandom());
      end else if (sel < 88) begin
         it.operation = OP_FREE;
         if (live_offsets.size() > 0 && $urandom_range(0, 9) < 7)
            it.free_offset =
               20'(live_offsets[$urandom_range(0, live_offsets.size() - 1)]);
         else if ($urandom_range(0, 1) == 1)
            it.free_offset = 20'($urandom_range(0, POOL_BYTES - 1));
         else
            it.free_offset = 20'($urandom());
         if ($urandom_range(0, 3) == 0) it.size_bytes = 20'($urandom());
      end else if (sel < 95) begin
         it.operation = OP_SWEEP;
      end else begin
         it.operation  = OP_NOP;
         it.size_bytes = 20'($urandom());
      end
      return it;
   endfunction

   task automatic test_random(int count, bit no_idle);
      quiet = no_idle;
      repeat (count) send_item(random_item());
      end_burst();
      quiet = 1'b0;
   endtask

   // receiver holds off while items keep coming, so the input stalls
   task automatic test_backpressure();
      hold_ticket++;
      repeat (8) send_item(random_item());
      end_burst();
   endtask

   // sender pauses until every result is back
   task automatic test_drain_pause();
      wait_drained();
      repeat (5) send_item(random_item());
      end_burst();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_before_ready();
      test_alloc_edges();
      test_free_edges();
      test_sweep_and_misc();
      test_random(60, 1'b1);
      test_backpressure();
      test_random(100, 1'b0);
      test_drain_pause();
      test_random(90, 1'b0);
      wait_drained();
      repeat (3200) @(posedge clock);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // run limit
   initial begin
      #20000000;
      $display("tb: failure");
      $finish;
   end

endmodule
